// ----- src/scfb_pkg.sv -----
// ----------------------------------------------------------------------------
// scfb_pkg
// Shared types, wire constants and the CRC-16/Modbus byte update for the
// stuffed CRC frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package scfb_pkg;

  localparam logic [7:0]  MARK_BYTE  = 8'hAA;
  localparam logic [7:0]  HEAD_BYTE  = 8'hCC;
  localparam logic [7:0]  TAIL_BYTE  = 8'hEE;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam int          QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       start;
    logic       has_data;
    logic       last;
    logic [7:0] slave_id;
    logic [7:0] sync;
    logic [7:0] frame_type;
    logic [7:0] data_byte;
  } entry_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/scfb_front.sv -----
// ----------------------------------------------------------------------------
// scfb_front
// Accepts input requests, tracks the open frame and the sync count, drops
// requests that produce no bytes and queues the rest for the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module scfb_front
  import scfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic       start_req,
  input  wire logic [7:0] slave_id,
  input  wire logic [7:0] frame_type,
  input  wire logic       has_data,
  input  wire logic [7:0] data_byte,
  input  wire logic       last,
  input  wire logic       q_full,
  output      logic       q_push,
  output      entry_t     q_entry
);

  logic       in_frame;
  logic [7:0] sync_count;
  logic [7:0] frame_sync;
  logic       accept;
  logic       active;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign active   = start_req || in_frame;
  assign q_push   = accept && active && (start_req || has_data || last);

  always_comb begin
    q_entry.start      = start_req;
    q_entry.has_data   = has_data;
    q_entry.last       = last;
    q_entry.slave_id   = slave_id;
    q_entry.sync       = start_req ? sync_count : frame_sync;
    q_entry.frame_type = frame_type;
    q_entry.data_byte  = data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      sync_count <= 8'h00;
      frame_sync <= 8'h00;
    end else if (accept && active) begin
      if (start_req) begin
        frame_sync <= sync_count;
        sync_count <= sync_count + 8'h01;
      end
      in_frame <= !last;
    end
  end

endmodule

`default_nettype wire

// ----- src/scfb_queue.sv -----
// ----------------------------------------------------------------------------
// scfb_queue
// Two-entry queue of classified requests between the front and the byte
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module scfb_queue
  import scfb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output      logic   full,
  output      logic   head_valid,
  output      entry_t head
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            slots [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_pop;

  assign full       = (count == CntW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/scfb_back.sv -----
// ----------------------------------------------------------------------------
// scfb_back
// Byte sequencer: walks the wire bytes of the request at the queue head,
// one byte per cycle while out_ready allows, doubles every stuffed 0xAA, updates the CRC and
// drives the registered output port.
// ----------------------------------------------------------------------------
`default_nettype none

module scfb_back
  import scfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire entry_t     head,
  output      logic       pop,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] out_byte,
  output      logic       run_end,
  output      logic       frame_end,
  output      logic [7:0] sync_used
);

  typedef enum logic [3:0] {
    ST_HDR0,
    ST_HDR1,
    ST_SID,
    ST_SYNC,
    ST_TYPE,
    ST_DATA,
    ST_CRCLO,
    ST_CRCHI,
    ST_TAIL0,
    ST_TAIL1
  } step_t;

  localparam int NSteps = 10;

  step_t       pos;
  logic        phase;
  logic [15:0] crc;

  logic [NSteps-1:0] needed;
  step_t             cur;
  logic              found;
  logic              more;
  logic              advance;
  logic [7:0]        cur_byte;
  logic              stuffed;
  logic              body;
  logic              dup_now;
  logic              entry_done;
  logic [15:0]       crc_base;
  logic [15:0]       crc_next;

  always_comb begin
    needed = {{4{head.last}}, head.has_data, {5{head.start}}};
    cur    = pos;
    found  = 1'b0;
    for (int i = 0; i < NSteps; i++) begin
      if (!found && (4'(i) >= pos) && needed[i]) begin
        cur   = step_t'(i);
        found = 1'b1;
      end
    end
    more = 1'b0;
    for (int i = 0; i < NSteps; i++) begin
      if ((4'(i) > cur) && needed[i]) begin
        more = 1'b1;
      end
    end
  end

  always_comb begin
    stuffed  = 1'b0;
    body     = 1'b0;
    cur_byte = MARK_BYTE;
    case (cur)
      ST_HDR0:  cur_byte = MARK_BYTE;
      ST_HDR1:  cur_byte = HEAD_BYTE;
      ST_SID: begin
        cur_byte = head.slave_id;
        stuffed  = 1'b1;
        body     = 1'b1;
      end
      ST_SYNC: begin
        cur_byte = head.sync;
        stuffed  = 1'b1;
        body     = 1'b1;
      end
      ST_TYPE: begin
        cur_byte = head.frame_type;
        stuffed  = 1'b1;
        body     = 1'b1;
      end
      ST_DATA: begin
        cur_byte = head.data_byte;
        stuffed  = 1'b1;
        body     = 1'b1;
      end
      ST_CRCLO: begin
        cur_byte = crc[7:0];
        stuffed  = 1'b1;
      end
      ST_CRCHI: begin
        cur_byte = crc[15:8];
        stuffed  = 1'b1;
      end
      ST_TAIL0: cur_byte = MARK_BYTE;
      ST_TAIL1: cur_byte = TAIL_BYTE;
      default:  cur_byte = MARK_BYTE;
    endcase
  end

  assign advance    = head_valid && (!out_valid || out_ready);
  assign dup_now    = stuffed && (cur_byte == MARK_BYTE) && !phase;
  assign entry_done = !dup_now && !more;
  assign pop        = advance && entry_done;
  assign crc_base   = (cur == ST_SID) ? CRC_INIT : crc;
  assign crc_next   = crc_feed(crc_base, cur_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= ST_HDR0;
      phase     <= 1'b0;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (body && !phase) begin
          crc <= crc_next;
        end
        if (dup_now) begin
          pos   <= cur;
          phase <= 1'b1;
        end else if (more) begin
          pos   <= step_t'(cur + 4'd1);
          phase <= 1'b0;
        end else begin
          pos   <= ST_HDR0;
          phase <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte  <= cur_byte;
      run_end   <= entry_done;
      frame_end <= (cur == ST_TAIL1);
      sync_used <= head.sync;
    end
  end

endmodule

`default_nettype wire

// ----- src/stuffed_crc_frame_builder_top.sv -----
// ----------------------------------------------------------------------------
// stuffed_crc_frame_builder_top
// Byte-stuffed command framer with CRC-16/Modbus, one payload byte per
// request in, one or more wire bytes per request out.
// ----------------------------------------------------------------------------
// A request is taken whenever the two-entry queue has room, so input and
// output run independently. The byte sequencer emits one wire byte per
// cycle unless out_ready holds it back. A request produces 1 or 2 wire
// bytes for a payload byte (2 when the byte is 0xAA), up to 8 for a start
// and up to 6 for a close, at most 16 in all. Requests that produce no
// bytes (outside a frame, or in a frame with no start, payload or close)
// are absorbed by the front. run_end marks the last byte of each request
// and frame_end the final 0xEE of a frame.
`default_nettype none

module stuffed_crc_frame_builder_top
  import scfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic       start_req,
  input  wire logic [7:0] slave_id,
  input  wire logic [7:0] frame_type,
  input  wire logic       has_data,
  input  wire logic [7:0] data_byte,
  input  wire logic       last,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] out_byte,
  output      logic       run_end,
  output      logic       frame_end,
  output      logic [7:0] sync_used
);

  logic   q_full;
  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  logic   q_head_valid;
  entry_t q_head;

  scfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_req  (start_req),
    .slave_id   (slave_id),
    .frame_type (frame_type),
    .has_data   (has_data),
    .data_byte  (data_byte),
    .last       (last),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  scfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  scfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .frame_end  (frame_end),
    .sync_used  (sync_used)
  );

endmodule

`default_nettype wire
